### hw/rtl/blk3_pkg.sv
package blk3_pkg;

   typedef logic [31:0] word_type;

   localparam logic [1:0] OP_LOAD_CV  = 2'd0;
   localparam logic [1:0] OP_LOAD_MSG = 2'd1;
   localparam logic [1:0] OP_COMPRESS = 2'd2;

   localparam int NUM_ROUNDS = 7;
   localparam logic [2:0] LAST_ROUND = 3'(NUM_ROUNDS - 1);

   localparam word_type IV_WORDS [4] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A
   };

   localparam logic [3:0] SCHED [NUM_ROUNDS][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
        4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8},
      '{4'd3, 4'd4, 4'd10, 4'd12, 4'd13, 4'd2, 4'd7, 4'd14,
        4'd6, 4'd5, 4'd9, 4'd0, 4'd11, 4'd15, 4'd8, 4'd1},
      '{4'd10, 4'd7, 4'd12, 4'd9, 4'd14, 4'd3, 4'd13, 4'd15,
        4'd4, 4'd0, 4'd11, 4'd2, 4'd5, 4'd8, 4'd1, 4'd6},
      '{4'd12, 4'd13, 4'd9, 4'd11, 4'd15, 4'd10, 4'd14, 4'd8,
        4'd7, 4'd2, 4'd5, 4'd3, 4'd0, 4'd1, 4'd6, 4'd4},
      '{4'd9, 4'd14, 4'd11, 4'd5, 4'd8, 4'd12, 4'd15, 4'd1,
        4'd13, 4'd3, 4'd0, 4'd10, 4'd2, 4'd6, 4'd4, 4'd7},
      '{4'd11, 4'd15, 4'd5, 4'd0, 4'd1, 4'd9, 4'd8, 4'd6,
        4'd14, 4'd10, 4'd2, 4'd12, 4'd3, 4'd4, 4'd7, 4'd13}
   };

endpackage

### hw/rtl/blake3_compression_top.sv
// Load items produce no result; busy stays low.
// A compress item runs 112 half-mix steps on one shared mixing unit
// (7 rounds of 16), a finalize step, then eight result items with rsp_strobe.
// The first result is on the ports after the run and finalize states; the receiver cannot stall.
// Reset clears the chaining and message stores to zero and returns the sequencer to idle.
module blake3_compression_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [2:0]         req_slot,
   input  blk3_pkg::word_type req_data_lo,
   input  blk3_pkg::word_type req_data_hi,
   input  logic [63:0]        req_block_counter,
   input  logic [6:0]         req_block_length,
   input  logic [7:0]         req_domain_flags,
   output logic               rsp_strobe,
   output blk3_pkg::word_type rsp_out_lo,
   output blk3_pkg::word_type rsp_out_hi,
   output logic [2:0]         rsp_out_index,
   output logic               rsp_last
);
   import blk3_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic [1:0] ROT_NORMAL    = 2'd0;
   localparam logic [1:0] ROT_TO_DIAG   = 2'd1;
   localparam logic [1:0] ROT_FROM_DIAG = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] round_ff, round_in;
   logic [3:0] pos_ff, pos_in;
   logic [2:0] cnt_ff, cnt_in;
   word_type   msg_word_ff, msg_word_in;
   word_type   v_ff [16];
   word_type   v_in [16];
   word_type   chain_ff [8];
   word_type   msg_ff [16];

   word_type   v_mix [16];
   word_type   v_rot [16];
   word_type   a_new, b_new, c_new, d_new;
   logic [1:0] rot_mode;
   logic [2:0] round_next;
   logic [3:0] pos_next;
   logic       accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   blk3_half_mix u_mix (
      .a           (v_ff[0]),
      .b           (v_ff[4]),
      .c           (v_ff[8]),
      .d           (v_ff[12]),
      .msg_word    (msg_word_ff),
      .second_half (pos_ff[0]),
      .a_new       (a_new),
      .b_new       (b_new),
      .c_new       (c_new),
      .d_new       (d_new)
   );

   always_comb begin
      v_mix     = v_ff;
      v_mix[0]  = a_new;
      v_mix[4]  = b_new;
      v_mix[8]  = c_new;
      v_mix[12] = d_new;
   end

   always_comb begin
      if (pos_ff == 4'd7) begin
         rot_mode = ROT_TO_DIAG;
      end else if (pos_ff == 4'd15) begin
         rot_mode = ROT_FROM_DIAG;
      end else begin
         rot_mode = ROT_NORMAL;
      end
   end

   // After the second half of each mix, every row shifts left by one word so the
   // next mix again works on column zero; phase changes fold in the diagonal shuffle.
   always_comb begin
      v_rot = v_mix;
      if (pos_ff[0]) begin
         for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
               case (rot_mode)
                  ROT_TO_DIAG: begin
                     v_rot[4*r+j] = v_mix[4*r + ((j + r + 1) % 4)];
                  end
                  ROT_FROM_DIAG: begin
                     v_rot[4*r+j] = v_mix[4*r + ((j + 5 - r) % 4)];
                  end
                  default: begin
                     v_rot[4*r+j] = v_mix[4*r + ((j + 1) % 4)];
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      pos_next   = pos_ff + 4'd1;
      round_next = (pos_ff == 4'd15) ? round_ff + 3'd1 : round_ff;
   end

   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      msg_word_in = msg_word_ff;
      v_in        = v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_COMPRESS) begin
               for (int i = 0; i < 8; i++) begin
                  v_in[i] = chain_ff[i];
               end
               for (int i = 0; i < 4; i++) begin
                  v_in[8+i] = IV_WORDS[i];
               end
               v_in[12]    = req_block_counter[31:0];
               v_in[13]    = req_block_counter[63:32];
               v_in[14]    = {25'd0, req_block_length};
               v_in[15]    = {24'd0, req_domain_flags};
               round_in    = 3'd0;
               pos_in      = 4'd0;
               msg_word_in = msg_ff[SCHED[0][0]];
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            v_in   = v_rot;
            pos_in = pos_next;
            if (round_ff == LAST_ROUND && pos_ff == 4'd15) begin
               state_in = ST_FIN;
            end else begin
               round_in    = round_next;
               msg_word_in = msg_ff[SCHED[round_next][pos_next]];
            end
         end
         ST_FIN: begin
            for (int i = 0; i < 8; i++) begin
               v_in[i]   = v_ff[i] ^ v_ff[i+8];
               v_in[i+8] = v_ff[i+8] ^ chain_ff[i];
            end
            cnt_in   = 3'd0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            for (int i = 0; i < 14; i++) begin
               v_in[i] = v_ff[i+2];
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= 3'd0;
         pos_ff   <= 4'd0;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_word_ff <= msg_word_in;
      v_ff        <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= '0;
         end
         for (int i = 0; i < 16; i++) begin
            msg_ff[i] <= '0;
         end
      end else if (accept) begin
         if (req_opcode == OP_LOAD_CV) begin
            chain_ff[{req_slot[1:0], 1'b0}] <= req_data_lo;
            chain_ff[{req_slot[1:0], 1'b1}] <= req_data_hi;
         end else if (req_opcode == OP_LOAD_MSG) begin
            msg_ff[{req_slot, 1'b0}] <= req_data_lo;
            msg_ff[{req_slot, 1'b1}] <= req_data_hi;
         end
      end
   end

   assign rsp_strobe    = (state_ff == ST_OUT);
   assign rsp_out_lo    = v_ff[0];
   assign rsp_out_hi    = v_ff[1];
   assign rsp_out_index = cnt_ff;
   assign rsp_last      = (cnt_ff == 3'd7);

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a compression");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy && !rsp_strobe)
      else $error("block still busy after the last item");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_out_index == $past(rsp_out_index) + 3'd1)
      else $error("result items not consecutive");

   a_compress_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == OP_COMPRESS |=> busy && !rsp_strobe)
      else $error("compress item did not start the sequencer");

endmodule

### hw/rtl/blk3_half_mix.sv
module blk3_half_mix (
   input  blk3_pkg::word_type a,
   input  blk3_pkg::word_type b,
   input  blk3_pkg::word_type c,
   input  blk3_pkg::word_type d,
   input  blk3_pkg::word_type msg_word,
   input  logic               second_half,
   output blk3_pkg::word_type a_new,
   output blk3_pkg::word_type b_new,
   output blk3_pkg::word_type c_new,
   output blk3_pkg::word_type d_new
);
   import blk3_pkg::*;

   word_type dx;
   word_type bx;

   always_comb begin
      a_new = a + b + msg_word;
      dx    = d ^ a_new;
      d_new = second_half ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
      c_new = c + d_new;
      bx    = b ^ c_new;
      b_new = second_half ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
   end

endmodule

### tb/blake3_compression_checker.sv
`timescale 1ns / 100ps

module blake3_compression_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [2:0]         req_slot,
   input  blk3_pkg::word_type req_data_lo,
   input  blk3_pkg::word_type req_data_hi,
   input  logic [63:0]        req_block_counter,
   input  logic [6:0]         req_block_length,
   input  logic [7:0]         req_domain_flags,
   input  logic               rsp_strobe,
   input  blk3_pkg::word_type rsp_out_lo,
   input  blk3_pkg::word_type rsp_out_hi,
   input  logic [2:0]         rsp_out_index,
   input  logic               rsp_last,
   output int                 mismatch_count,
   output int                 pending_results
);
   import blk3_pkg::*;

   localparam word_type CHAIN_IV [4] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A
   };
   localparam int MSG_PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};
   localparam int ROUND_COUNT = 7;

   typedef struct packed {
      word_type   lo;
      word_type   hi;
      logic [2:0] index;
      logic       last;
   } out_pair_type;

   word_type     chain_words [8];
   word_type     message_words [16];
   word_type     mix_state [16];
   out_pair_type expected_pairs [$];

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic g_mix(input int a, input int b, input int c, input int d,
                        input word_type mx, input word_type my);
      mix_state[a] = mix_state[a] + mix_state[b] + mx;
      mix_state[d] = rotr(mix_state[d] ^ mix_state[a], 16);
      mix_state[c] = mix_state[c] + mix_state[d];
      mix_state[b] = rotr(mix_state[b] ^ mix_state[c], 12);
      mix_state[a] = mix_state[a] + mix_state[b] + my;
      mix_state[d] = rotr(mix_state[d] ^ mix_state[a], 8);
      mix_state[c] = mix_state[c] + mix_state[d];
      mix_state[b] = rotr(mix_state[b] ^ mix_state[c], 7);
   endtask

   task automatic predict_compression(input logic [63:0] counter, input logic [6:0] length,
                                      input logic [7:0] flags);
      word_type     sched_words [16];
      word_type     permuted [16];
      word_type     out_words [16];
      out_pair_type pair;
      for (int i = 0; i < 8; i++) begin
         mix_state[i] = chain_words[i];
      end
      for (int i = 0; i < 4; i++) begin
         mix_state[8 + i] = CHAIN_IV[i];
      end
      mix_state[12] = counter[31:0];
      mix_state[13] = counter[63:32];
      mix_state[14] = {25'd0, length};
      mix_state[15] = {24'd0, flags};
      for (int i = 0; i < 16; i++) begin
         sched_words[i] = message_words[i];
      end
      for (int r = 0; r < ROUND_COUNT; r++) begin
         g_mix(0, 4, 8, 12, sched_words[0], sched_words[1]);
         g_mix(1, 5, 9, 13, sched_words[2], sched_words[3]);
         g_mix(2, 6, 10, 14, sched_words[4], sched_words[5]);
         g_mix(3, 7, 11, 15, sched_words[6], sched_words[7]);
         g_mix(0, 5, 10, 15, sched_words[8], sched_words[9]);
         g_mix(1, 6, 11, 12, sched_words[10], sched_words[11]);
         g_mix(2, 7, 8, 13, sched_words[12], sched_words[13]);
         g_mix(3, 4, 9, 14, sched_words[14], sched_words[15]);
         for (int i = 0; i < 16; i++) begin
            permuted[i] = sched_words[MSG_PERM[i]];
         end
         for (int i = 0; i < 16; i++) begin
            sched_words[i] = permuted[i];
         end
      end
      for (int i = 0; i < 8; i++) begin
         out_words[i] = mix_state[i] ^ mix_state[i + 8];
         out_words[i + 8] = mix_state[i + 8] ^ chain_words[i];
      end
      for (int i = 0; i < 8; i++) begin
         pair.lo = out_words[2 * i];
         pair.hi = out_words[2 * i + 1];
         pair.index = 3'(i);
         pair.last = (i == 7);
         expected_pairs.push_back(pair);
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_results = 0;
   end

   always @(posedge clock) begin : monitor
      out_pair_type exp_pair;
      int           pos;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_words[i] = '0;
         end
         for (int i = 0; i < 16; i++) begin
            message_words[i] = '0;
         end
         expected_pairs.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_pairs.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected result lo=%h hi=%h index=%0d last=%b", $realtime,
                           rsp_out_lo, rsp_out_hi, rsp_out_index, rsp_last);
               end
               mismatch_count++;
            end else begin
               exp_pair = expected_pairs.pop_front();
               if (rsp_out_lo !== exp_pair.lo || rsp_out_hi !== exp_pair.hi ||
                   rsp_out_index !== exp_pair.index || rsp_last !== exp_pair.last) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: mismatch expected lo=%h hi=%h index=%0d last=%b", $realtime,
                              exp_pair.lo, exp_pair.hi, exp_pair.index, exp_pair.last);
                     $display("%0t:          actual   lo=%h hi=%h index=%0d last=%b", $realtime,
                              rsp_out_lo, rsp_out_hi, rsp_out_index, rsp_last);
                  end
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            case (req_opcode)
               OP_LOAD_CV: begin
                  pos = 2 * int'(req_slot[1:0]);
                  chain_words[pos] = req_data_lo;
                  chain_words[pos + 1] = req_data_hi;
               end
               OP_LOAD_MSG: begin
                  pos = 2 * int'(req_slot);
                  message_words[pos] = req_data_lo;
                  message_words[pos + 1] = req_data_hi;
               end
               OP_COMPRESS: begin
                  predict_compression(req_block_counter, req_block_length, req_domain_flags);
               end
               default: begin
               end
            endcase
         end
      end
      pending_results = expected_pairs.size();
   end

endmodule

### tb/blake3_compression_top_tb.sv
`timescale 1ns / 100ps

module blake3_compression_top_tb;
   import blk3_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int DIRECTED_ITEMS = 25;
   localparam int PHASE_ITEMS = 102;
   localparam int DRAIN_CYCLES = 130;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_opcode = '0;
   logic [2:0]  req_slot = '0;
   word_type    req_data_lo = '0;
   word_type    req_data_hi = '0;
   logic [63:0] req_block_counter = '0;
   logic [6:0]  req_block_length = '0;
   logic [7:0]  req_domain_flags = '0;
   logic        busy;
   logic        rsp_strobe;
   word_type    rsp_out_lo;
   word_type    rsp_out_hi;
   logic [2:0]  rsp_out_index;
   logic        rsp_last;

   int mismatch_count;
   int pending_results;
   int items_sent = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   blake3_compression_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_slot          (req_slot),
      .req_data_lo       (req_data_lo),
      .req_data_hi       (req_data_hi),
      .req_block_counter (req_block_counter),
      .req_block_length  (req_block_length),
      .req_domain_flags  (req_domain_flags),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_lo        (rsp_out_lo),
      .rsp_out_hi        (rsp_out_hi),
      .rsp_out_index     (rsp_out_index),
      .rsp_last          (rsp_last)
   );

   blake3_compression_checker digest_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_slot          (req_slot),
      .req_data_lo       (req_data_lo),
      .req_data_hi       (req_data_hi),
      .req_block_counter (req_block_counter),
      .req_block_length  (req_block_length),
      .req_domain_flags  (req_domain_flags),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_lo        (rsp_out_lo),
      .rsp_out_hi        (rsp_out_hi),
      .rsp_out_index     (rsp_out_index),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .pending_results   (pending_results)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic word_type rand_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_counter();
      case ($urandom_range(3))
         0: return {32'd0, 32'($urandom_range(15))};
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input logic [1:0] op, input logic [2:0] slot,
                            input word_type lo, input word_type hi,
                            input logic [63:0] counter, input logic [6:0] length,
                            input logic [7:0] flags);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_slot <= slot;
      req_data_lo <= lo;
      req_data_hi <= hi;
      req_block_counter <= counter;
      req_block_length <= length;
      req_domain_flags <= flags;
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      if (op != OP_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic load_pair(input logic [1:0] op, input logic [2:0] slot,
                            input word_type lo, input word_type hi);
      send_item(op, slot, lo, hi, {$urandom, $urandom}, 7'($urandom_range(127)),
                8'($urandom_range(255)));
   endtask

   task automatic compress_block(input logic [63:0] counter, input logic [6:0] length,
                                 input logic [7:0] flags);
      send_item(OP_COMPRESS, 3'($urandom_range(7)), $urandom, $urandom, counter, length, flags);
   endtask

   task automatic send_block();
      int order [8];
      int j;
      int tmp;
      int count;
      if ($urandom_range(1) == 1) begin
         for (int s = 0; s < 4; s++) begin
            load_pair(OP_LOAD_CV, {1'($urandom_range(1)), 2'(s)}, rand_word(), rand_word());
         end
      end else begin
         repeat ($urandom_range(3)) begin
            load_pair(OP_LOAD_CV, 3'($urandom_range(7)), rand_word(), rand_word());
         end
      end
      for (int i = 0; i < 8; i++) begin
         order[i] = i;
      end
      for (int i = 7; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      count = ($urandom_range(3) == 0) ? $urandom_range(7) : 8;
      for (int i = 0; i < count; i++) begin
         load_pair(OP_LOAD_MSG, 3'(order[i]), rand_word(), rand_word());
      end
      compress_block(rand_counter(),
                     ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64)),
                     8'($urandom_range(255)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 3)) begin
         send_item(2'($urandom_range(3)), 3'($urandom_range(7)), rand_word(), rand_word(),
                   rand_counter(), 7'($urandom_range(127)), 8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Compression of the all-zero stores left by reset.
      compress_block(64'd0, 7'd0, 8'd0);
      send_item(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                7'd127, 8'hFF);
      // High chaining slots alias onto the low ones.
      load_pair(OP_LOAD_CV, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int s = 5; s < 8; s++) begin
         load_pair(OP_LOAD_CV, 3'(s), $urandom, $urandom);
      end
      load_pair(OP_LOAD_MSG, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int s = 1; s < 8; s++) begin
         load_pair(OP_LOAD_MSG, 3'(s), $urandom, $urandom);
      end
      compress_block(64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 8'hFF);
      load_pair(OP_LOAD_CV, 3'd0, 32'h0000_0000, 32'h0000_0000);
      compress_block(64'h8000_0000_0000_0001, 7'd127, 8'h0B);
      send_item(OP_UNUSED, 3'd0, 32'h0000_0000, 32'h0000_0000, 64'd0, 7'd0, 8'd0);
      compress_block(64'd1, 7'd65, 8'h01);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: idle_pct = 75;
            2: idle_pct = 10;
            default: idle_pct = 0;
         endcase
         while (items_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) begin
            if ($urandom_range(99) < 75) begin
               send_block();
            end else begin
               send_noise();
            end
         end
      end

      start <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
